### src/sit_pkg.sv
// shared types for the segment intersection test pipeline
package sit_pkg;

    // per-stage tag that travels alongside the arithmetic payload
    typedef struct packed {
        logic valid;
        logic box_ok;
    } t_stage_tag;

endpackage

### src/sit_box_axis.sv
// bounding-box rejection on one axis: b lies wholly beyond one end of a
module sit_box_axis #(
    parameter int unsigned COORD_WIDTH = 16
) (
    input  logic signed [COORD_WIDTH-1:0] i_v1,
    input  logic signed [COORD_WIDTH-1:0] i_v2,
    input  logic signed [COORD_WIDTH-1:0] i_w1,
    input  logic signed [COORD_WIDTH-1:0] i_w2,
    output logic                          o_reject
);

    logic fwd;
    logic below_v1;
    logic above_v1;
    logic below_v2;
    logic above_v2;

    // strict comparisons of both endpoints of b against each end of a
    assign fwd      = i_v1 < i_v2;
    assign below_v1 = (i_w1 < i_v1) && (i_w2 < i_v1);
    assign above_v1 = (i_w1 > i_v1) && (i_w2 > i_v1);
    assign below_v2 = (i_w1 < i_v2) && (i_w2 < i_v2);
    assign above_v2 = (i_w1 > i_v2) && (i_w2 > i_v2);

    // branch on the direction of a along this axis
    assign o_reject = fwd ? (below_v1 || above_v2) : (above_v1 || below_v2);

endmodule

### src/sit_cross_mul.sv
// product stage: the six signed products of the three cross products, registered
module sit_cross_mul #(
    parameter int unsigned COORD_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  sit_pkg::t_stage_tag              i_tag,
    input  logic signed [COORD_WIDTH:0]      i_ax,
    input  logic signed [COORD_WIDTH:0]      i_az,
    input  logic signed [COORD_WIDTH:0]      i_bx,
    input  logic signed [COORD_WIDTH:0]      i_bz,
    input  logic signed [COORD_WIDTH:0]      i_dx,
    input  logic signed [COORD_WIDTH:0]      i_dz,
    output sit_pkg::t_stage_tag              o_tag,
    output logic signed [2*COORD_WIDTH+1:0]  o_dx_az,
    output logic signed [2*COORD_WIDTH+1:0]  o_dz_ax,
    output logic signed [2*COORD_WIDTH+1:0]  o_dx_bz,
    output logic signed [2*COORD_WIDTH+1:0]  o_dz_bx,
    output logic signed [2*COORD_WIDTH+1:0]  o_ax_bz,
    output logic signed [2*COORD_WIDTH+1:0]  o_az_bx
);
    import sit_pkg::*;

    localparam int unsigned PROD_WIDTH = 2 * COORD_WIDTH + 2;

    t_stage_tag                   r_tag;
    logic signed [PROD_WIDTH-1:0] r_dx_az;
    logic signed [PROD_WIDTH-1:0] r_dz_ax;
    logic signed [PROD_WIDTH-1:0] r_dx_bz;
    logic signed [PROD_WIDTH-1:0] r_dz_bx;
    logic signed [PROD_WIDTH-1:0] r_ax_bz;
    logic signed [PROD_WIDTH-1:0] r_az_bx;

    logic signed [PROD_WIDTH-1:0] n_dx_az;
    logic signed [PROD_WIDTH-1:0] n_dz_ax;
    logic signed [PROD_WIDTH-1:0] n_dx_bz;
    logic signed [PROD_WIDTH-1:0] n_dz_bx;
    logic signed [PROD_WIDTH-1:0] n_ax_bz;
    logic signed [PROD_WIDTH-1:0] n_az_bx;

    // full-width signed products, no wrap possible
    assign n_dx_az = PROD_WIDTH'(i_dx) * PROD_WIDTH'(i_az);
    assign n_dz_ax = PROD_WIDTH'(i_dz) * PROD_WIDTH'(i_ax);
    assign n_dx_bz = PROD_WIDTH'(i_dx) * PROD_WIDTH'(i_bz);
    assign n_dz_bx = PROD_WIDTH'(i_dz) * PROD_WIDTH'(i_bx);
    assign n_ax_bz = PROD_WIDTH'(i_ax) * PROD_WIDTH'(i_bz);
    assign n_az_bx = PROD_WIDTH'(i_az) * PROD_WIDTH'(i_bx);

    // stage tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    // product registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx_az <= n_dx_az;
            r_dz_ax <= n_dz_ax;
            r_dx_bz <= n_dx_bz;
            r_dz_bx <= n_dz_bx;
            r_ax_bz <= n_ax_bz;
            r_az_bx <= n_az_bx;
        end
    end

    assign o_tag   = r_tag;
    assign o_dx_az = r_dx_az;
    assign o_dz_ax = r_dz_ax;
    assign o_dx_bz = r_dx_bz;
    assign o_dz_bx = r_dz_bx;
    assign o_ax_bz = r_ax_bz;
    assign o_az_bx = r_az_bx;

endmodule

### src/sit_cross_decide.sv
// cross product stage and the sign and magnitude decision
module sit_cross_decide #(
    parameter int unsigned COORD_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  sit_pkg::t_stage_tag              i_tag,
    input  logic signed [2*COORD_WIDTH+1:0]  i_dx_az,
    input  logic signed [2*COORD_WIDTH+1:0]  i_dz_ax,
    input  logic signed [2*COORD_WIDTH+1:0]  i_dx_bz,
    input  logic signed [2*COORD_WIDTH+1:0]  i_dz_bx,
    input  logic signed [2*COORD_WIDTH+1:0]  i_ax_bz,
    input  logic signed [2*COORD_WIDTH+1:0]  i_az_bx,
    output sit_pkg::t_stage_tag              o_tag,
    output logic                             o_hit
);
    import sit_pkg::*;

    localparam int unsigned CROSS_WIDTH = 2 * COORD_WIDTH + 3;

    t_stage_tag                    r_tag;
    logic signed [CROSS_WIDTH-1:0] r_da;
    logic signed [CROSS_WIDTH-1:0] r_db;
    logic signed [CROSS_WIDTH-1:0] r_ab;

    logic signed [CROSS_WIDTH-1:0] n_da;
    logic signed [CROSS_WIDTH-1:0] n_db;
    logic signed [CROSS_WIDTH-1:0] n_ab;

    logic da_neg;
    logic db_ok;
    logic ab_ok;

    // dcrossa, dcrossb, acrossb with one guard bit
    assign n_da = CROSS_WIDTH'(i_dx_az) - CROSS_WIDTH'(i_dz_ax);
    assign n_db = CROSS_WIDTH'(i_dx_bz) - CROSS_WIDTH'(i_dz_bx);
    assign n_ab = CROSS_WIDTH'(i_ax_bz) - CROSS_WIDTH'(i_az_bx);

    // stage tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    // cross product registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_da <= n_da;
            r_db <= n_db;
            r_ab <= n_ab;
        end
    end

    // same sign as dcrossa (zero as positive) and magnitude not above it;
    // with equal signs the magnitude test is a plain signed compare
    assign da_neg = r_da[CROSS_WIDTH-1];
    assign db_ok  = (r_db[CROSS_WIDTH-1] == da_neg) && (da_neg ? (r_db >= r_da) : (r_db <= r_da));
    assign ab_ok  = (r_ab[CROSS_WIDTH-1] == da_neg) && (da_neg ? (r_ab >= r_da) : (r_ab <= r_da));

    assign o_tag = r_tag;
    assign o_hit = r_tag.box_ok && db_ok && ab_ok;

endmodule

### src/segment_intersection_test.sv
// top level of the 2d segment intersection test pipeline
// Answers whether segment a and segment b touch or cross, endpoints included,
// for one pair of segments per transaction. The block is fully pipelined and
// takes a new transaction every cycle while o_stall is low; each transaction
// passes through five register stages: input capture, box test and differences,
// products, cross products, and the result register; the accepting edge loads
// the first of them. Output stall holds the pipeline only as far back as it is
// full, so empty stages keep accepting.
module segment_intersection_test #(
    parameter int unsigned COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_seg_a_x1,
    input  logic signed [COORD_WIDTH-1:0] i_seg_a_z1,
    input  logic signed [COORD_WIDTH-1:0] i_seg_a_x2,
    input  logic signed [COORD_WIDTH-1:0] i_seg_a_z2,
    input  logic signed [COORD_WIDTH-1:0] i_seg_b_x1,
    input  logic signed [COORD_WIDTH-1:0] i_seg_b_z1,
    input  logic signed [COORD_WIDTH-1:0] i_seg_b_x2,
    input  logic signed [COORD_WIDTH-1:0] i_seg_b_z2,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_crosses
);
    import sit_pkg::*;

    localparam int unsigned DIFF_WIDTH = COORD_WIDTH + 1;
    localparam int unsigned PROD_WIDTH = 2 * COORD_WIDTH + 2;

    // input capture registers
    logic                          r_in_valid;
    logic signed [COORD_WIDTH-1:0] r_a_x1;
    logic signed [COORD_WIDTH-1:0] r_a_z1;
    logic signed [COORD_WIDTH-1:0] r_a_x2;
    logic signed [COORD_WIDTH-1:0] r_a_z2;
    logic signed [COORD_WIDTH-1:0] r_b_x1;
    logic signed [COORD_WIDTH-1:0] r_b_z1;
    logic signed [COORD_WIDTH-1:0] r_b_x2;
    logic signed [COORD_WIDTH-1:0] r_b_z2;

    // difference stage
    t_stage_tag                   r_s1_tag;
    t_stage_tag                   n_s1_tag;
    logic signed [DIFF_WIDTH-1:0] r_ax, r_az, r_bx, r_bz, r_dx, r_dz;
    logic signed [DIFF_WIDTH-1:0] n_ax, n_az, n_bx, n_bz, n_dx, n_dz;
    logic                         reject_x;
    logic                         reject_z;

    // product stage outputs
    t_stage_tag                   s2_tag;
    logic signed [PROD_WIDTH-1:0] p_dx_az, p_dz_ax, p_dx_bz, p_dz_bx, p_ax_bz, p_az_bx;

    // cross stage outputs
    t_stage_tag                   s3_tag;
    logic                         s3_hit;

    // result register
    logic                         r_out_valid;
    logic                         r_crosses;

    // per-stage advance: a stage loads when it is empty or its successor moves
    logic en_out, en_s3, en_s2, en_s1, en_in;

    assign en_out  = !r_out_valid || !i_stall;
    assign en_s3   = !s3_tag.valid || en_out;
    assign en_s2   = !s2_tag.valid || en_s3;
    assign en_s1   = !r_s1_tag.valid || en_s2;
    assign en_in   = !r_in_valid || en_s1;
    assign o_stall = !en_in;

    // input capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en_in) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_in) begin
            r_a_x1 <= i_seg_a_x1;
            r_a_z1 <= i_seg_a_z1;
            r_a_x2 <= i_seg_a_x2;
            r_a_z2 <= i_seg_a_z2;
            r_b_x1 <= i_seg_b_x1;
            r_b_z1 <= i_seg_b_z1;
            r_b_x2 <= i_seg_b_x2;
            r_b_z2 <= i_seg_b_z2;
        end
    end

    // bounding-box rejection per axis
    sit_box_axis #(.COORD_WIDTH(COORD_WIDTH)) u_box_x (
        .i_v1     (r_a_x1),
        .i_v2     (r_a_x2),
        .i_w1     (r_b_x1),
        .i_w2     (r_b_x2),
        .o_reject (reject_x)
    );

    sit_box_axis #(.COORD_WIDTH(COORD_WIDTH)) u_box_z (
        .i_v1     (r_a_z1),
        .i_v2     (r_a_z2),
        .i_w1     (r_b_z1),
        .i_w2     (r_b_z2),
        .o_reject (reject_z)
    );

    // edge vectors at one extra bit
    assign n_ax = DIFF_WIDTH'(r_a_x2) - DIFF_WIDTH'(r_a_x1);
    assign n_az = DIFF_WIDTH'(r_a_z2) - DIFF_WIDTH'(r_a_z1);
    assign n_bx = DIFF_WIDTH'(r_b_x1) - DIFF_WIDTH'(r_a_x1);
    assign n_bz = DIFF_WIDTH'(r_b_z1) - DIFF_WIDTH'(r_a_z1);
    assign n_dx = DIFF_WIDTH'(r_b_x2) - DIFF_WIDTH'(r_b_x1);
    assign n_dz = DIFF_WIDTH'(r_b_z2) - DIFF_WIDTH'(r_b_z1);

    assign n_s1_tag.valid  = r_in_valid;
    assign n_s1_tag.box_ok = !(reject_x || reject_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tag <= '0;
        end else if (en_s1) begin
            r_s1_tag <= n_s1_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s1) begin
            r_ax <= n_ax;
            r_az <= n_az;
            r_bx <= n_bx;
            r_bz <= n_bz;
            r_dx <= n_dx;
            r_dz <= n_dz;
        end
    end

    // products
    sit_cross_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en_s2),
        .i_tag   (r_s1_tag),
        .i_ax    (r_ax),
        .i_az    (r_az),
        .i_bx    (r_bx),
        .i_bz    (r_bz),
        .i_dx    (r_dx),
        .i_dz    (r_dz),
        .o_tag   (s2_tag),
        .o_dx_az (p_dx_az),
        .o_dz_ax (p_dz_ax),
        .o_dx_bz (p_dx_bz),
        .o_dz_bx (p_dz_bx),
        .o_ax_bz (p_ax_bz),
        .o_az_bx (p_az_bx)
    );

    // cross products and decision
    sit_cross_decide #(.COORD_WIDTH(COORD_WIDTH)) u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en_s3),
        .i_tag   (s2_tag),
        .i_dx_az (p_dx_az),
        .i_dz_ax (p_dz_ax),
        .i_dx_bz (p_dx_bz),
        .i_dz_bx (p_dz_bx),
        .i_ax_bz (p_ax_bz),
        .i_az_bx (p_az_bx),
        .o_tag   (s3_tag),
        .o_hit   (s3_hit)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= s3_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_crosses <= s3_hit;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_crosses = r_crosses;

endmodule

### src/sit_checker.sv
// port-level checks for the segment intersection test, bound to the top level
module sit_checker #(
    parameter int unsigned COORD_WIDTH = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic signed [COORD_WIDTH-1:0] i_seg_a_x1,
    input logic signed [COORD_WIDTH-1:0] i_seg_a_z1,
    input logic signed [COORD_WIDTH-1:0] i_seg_a_x2,
    input logic signed [COORD_WIDTH-1:0] i_seg_a_z2,
    input logic signed [COORD_WIDTH-1:0] i_seg_b_x1,
    input logic signed [COORD_WIDTH-1:0] i_seg_b_z1,
    input logic signed [COORD_WIDTH-1:0] i_seg_b_x2,
    input logic signed [COORD_WIDTH-1:0] i_seg_b_z2,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic                          o_crosses
);

    // a stalled input transaction stays and holds its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid
            && $stable(i_seg_a_x1) && $stable(i_seg_a_z1)
            && $stable(i_seg_a_x2) && $stable(i_seg_a_z2)
            && $stable(i_seg_b_x1) && $stable(i_seg_b_z1)
            && $stable(i_seg_b_x2) && $stable(i_seg_b_z2))
        else $error("stalled input transaction changed or dropped");

    // a stalled result transaction stays and holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_crosses))
        else $error("stalled result changed or dropped");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // input back-pressure only when the result register is full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty result register");

    // input back-pressure only arises from output back-pressure
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output is free");

endmodule

bind segment_intersection_test sit_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sit_checker (.*);
